>>> hw/rtl/qdcm_pkg.sv
package qdcm_pkg;

	localparam int MaxQuadsDef = 64;
	localparam int MaxVarsDef = 64;

	// Variable ids arrive as six-bit fields, so no map needs more entries.
	localparam int VarIdW = 6;
	localparam int VarSpace = 1 << VarIdW;

	localparam logic [1:0] ClsRoot = 2'd1;
	localparam logic [1:0] ClsKept = 2'd2;

	typedef struct packed {
		logic               dv;
		logic [VarIdW-1:0]  d;
		logic               a2v;
		logic [VarIdW-1:0]  a2;
		logic               a1v;
		logic [VarIdW-1:0]  a1;
		logic [1:0]         cls;
	} quad_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_CLEAR,
		ACT_READ,
		ACT_MARK_ROOT,
		ACT_SWEEP_INIT,
		ACT_MARK_LIVE,
		ACT_EMIT_INIT,
		ACT_EMIT,
		ACT_DONE
	} act_t;

	typedef enum logic [1:0] {
		WAIT_NONE,
		WAIT_IN_LAST,
		WAIT_OUT_FREE
	} wait_t;

	typedef enum logic [1:0] {
		BR_NEXT,
		BR_ALWAYS,
		BR_MORE,
		BR_CHANGED
	} br_t;

	localparam int PcW = 4;
	typedef logic [PcW-1:0] pc_t;

	localparam pc_t StLoad      = 4'd0;
	localparam pc_t StClear     = 4'd1;
	localparam pc_t StRootRd    = 4'd2;
	localparam pc_t StRootMark  = 4'd3;
	localparam pc_t StSweepInit = 4'd4;
	localparam pc_t StSweepRd   = 4'd5;
	localparam pc_t StSweepMark = 4'd6;
	localparam pc_t StTest      = 4'd7;
	localparam pc_t StEmitInit  = 4'd8;
	localparam pc_t StEmitRd    = 4'd9;
	localparam pc_t StEmit      = 4'd10;
	localparam pc_t StDone      = 4'd11;

	typedef struct packed {
		act_t  act;
		wait_t wt;
		br_t   br;
		pc_t   target;
	} ctrl_t;

	typedef struct packed {
		logic in_last;
		logic out_free;
		logic more;
		logic changed;
	} flags_t;

	function automatic ctrl_t prog_rom(pc_t pc);
		ctrl_t c;
		c = '{act: ACT_NONE, wt: WAIT_NONE, br: BR_ALWAYS, target: StLoad};
		unique case (pc)
			StLoad: c = '{act: ACT_LOAD, wt: WAIT_IN_LAST, br: BR_NEXT, target: StLoad};
			StClear: c = '{act: ACT_CLEAR, wt: WAIT_NONE, br: BR_NEXT, target: StLoad};
			StRootRd: c = '{act: ACT_READ, wt: WAIT_NONE, br: BR_NEXT, target: StLoad};
			StRootMark: c = '{act: ACT_MARK_ROOT, wt: WAIT_NONE, br: BR_MORE, target: StRootRd};
			StSweepInit: c = '{act: ACT_SWEEP_INIT, wt: WAIT_NONE, br: BR_NEXT, target: StLoad};
			StSweepRd: c = '{act: ACT_READ, wt: WAIT_NONE, br: BR_NEXT, target: StLoad};
			StSweepMark: c = '{act: ACT_MARK_LIVE, wt: WAIT_NONE, br: BR_MORE,
				target: StSweepRd};
			StTest: c = '{act: ACT_NONE, wt: WAIT_NONE, br: BR_CHANGED, target: StSweepInit};
			StEmitInit: c = '{act: ACT_EMIT_INIT, wt: WAIT_NONE, br: BR_NEXT, target: StLoad};
			StEmitRd: c = '{act: ACT_READ, wt: WAIT_NONE, br: BR_NEXT, target: StLoad};
			StEmit: c = '{act: ACT_EMIT, wt: WAIT_OUT_FREE, br: BR_MORE, target: StEmitRd};
			StDone: c = '{act: ACT_DONE, wt: WAIT_NONE, br: BR_ALWAYS, target: StLoad};
			default: c = '{act: ACT_NONE, wt: WAIT_NONE, br: BR_ALWAYS, target: StLoad};
		endcase
		return c;
	endfunction

endpackage

>>> hw/rtl/qdcm_seq.sv
module qdcm_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  qdcm_pkg::flags_t flags,
	output qdcm_pkg::ctrl_t  ctrl,
	output logic             run
);

	qdcm_pkg::pc_t pc_q;
	qdcm_pkg::pc_t pc_next;
	logic          hold;
	logic          taken;

	always_comb begin
		ctrl = qdcm_pkg::prog_rom(pc_q);
		unique case (ctrl.wt)
			qdcm_pkg::WAIT_IN_LAST: hold = !flags.in_last;
			qdcm_pkg::WAIT_OUT_FREE: hold = !flags.out_free;
			default: hold = 1'b0;
		endcase
		unique case (ctrl.br)
			qdcm_pkg::BR_ALWAYS: taken = 1'b1;
			qdcm_pkg::BR_MORE: taken = flags.more;
			qdcm_pkg::BR_CHANGED: taken = flags.changed;
			default: taken = 1'b0;
		endcase
		run = !hold;
		if (hold) begin
			pc_next = pc_q;
		end else if (taken) begin
			pc_next = ctrl.target;
		end else begin
			pc_next = pc_q + qdcm_pkg::pc_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= qdcm_pkg::StLoad;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

>>> hw/rtl/quad_dead_code_marker.sv
// Marks dead code in a block of up to MAX_QUADS quadruples. Words are stored
// one per cycle while the block loads; the word with tlast starts the
// analysis, and no input is taken until every result of that block has been
// handed to the output register. The analysis is run by a small microcoded
// sequencer over a single-port quad memory, which reads and then handles each
// quad in turn: one root pass, then sweeps until one marks nothing new, then
// one output pass, which waits while the output register is stalled. The
// number of sweeps is at most the number of variables plus one.
module quad_dead_code_marker #(
	parameter int MAX_QUADS = qdcm_pkg::MaxQuadsDef,
	parameter int MAX_VARS = qdcm_pkg::MaxVarsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// arg1_var[5:0], arg1_valid[6], arg2_var[12:7], arg2_valid[13],
	// dest_var[19:14], dest_valid[20], zero fill
	input  logic [23:0] s_tdata,
	// op_class[1:0]
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// quad_index[5:0], live[6], zero fill
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

	localparam int IdxW = $clog2(MAX_QUADS);
	localparam int CntW = $clog2(MAX_QUADS + 1);
	localparam int VarDepth = (MAX_VARS < qdcm_pkg::VarSpace) ? MAX_VARS : qdcm_pkg::VarSpace;
	localparam int VarW = $clog2(VarDepth);

	qdcm_pkg::ctrl_t  ctrl;
	qdcm_pkg::flags_t flags;
	logic             run;

	qdcm_pkg::quad_t  mem [MAX_QUADS];
	qdcm_pkg::quad_t  wr_word;
	qdcm_pkg::quad_t  rd_q;

	logic [CntW-1:0]     count_q;
	logic [IdxW-1:0]     idx_q;
	logic [VarDepth-1:0] used_q;
	logic [VarDepth-1:0] mark_vec;
	logic                changed_q;
	logic                m_tvalid_q;
	logic [5:0]          out_idx_q;
	logic                out_live_q;
	logic                out_last_q;

	logic in_acc;
	logic wr_en;
	logic rd_en;
	logic more;
	logic dest_named;
	logic live;
	logic mark_en;

	function automatic logic names_var(logic valid, logic [qdcm_pkg::VarIdW-1:0] id);
		return valid && (32'(id) < 32'(MAX_VARS));
	endfunction

	qdcm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl),
		.run    (run)
	);

	assign s_tready = (ctrl.act == qdcm_pkg::ACT_LOAD);
	assign in_acc = s_tvalid && s_tready;
	assign wr_en = in_acc && (32'(count_q) < 32'(MAX_QUADS));
	assign rd_en = run && (ctrl.act == qdcm_pkg::ACT_READ);
	assign more = ((CntW'(idx_q) + CntW'(1)) != count_q);

	assign wr_word = '{dv: s_tdata[20], d: s_tdata[19:14], a2v: s_tdata[13],
		a2: s_tdata[12:7], a1v: s_tdata[6], a1: s_tdata[5:0], cls: s_tuser};

	assign flags = '{in_last: in_acc && s_tlast, out_free: !m_tvalid_q || m_tready,
		more: more, changed: changed_q};

	assign dest_named = names_var(rd_q.dv, rd_q.d);
	assign live = !(dest_named && !used_q[rd_q.d[VarW-1:0]]) ||
		(rd_q.cls == qdcm_pkg::ClsRoot) || (rd_q.cls == qdcm_pkg::ClsKept);

	always_comb begin
		mark_en = 1'b0;
		if (run && ctrl.act == qdcm_pkg::ACT_MARK_ROOT) begin
			mark_en = (rd_q.cls == qdcm_pkg::ClsRoot);
		end else if (run && ctrl.act == qdcm_pkg::ACT_MARK_LIVE) begin
			mark_en = dest_named && used_q[rd_q.d[VarW-1:0]];
		end
		mark_vec = '0;
		if (mark_en && names_var(rd_q.a1v, rd_q.a1)) begin
			mark_vec[rd_q.a1[VarW-1:0]] = 1'b1;
		end
		if (mark_en && names_var(rd_q.a2v, rd_q.a2)) begin
			mark_vec[rd_q.a2[VarW-1:0]] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IdxW-1:0]] <= wr_word;
		end
		if (rd_en) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
			used_q <= '0;
			changed_q <= 1'b0;
		end else begin
			if (wr_en) begin
				count_q <= count_q + CntW'(1);
			end
			if (run) begin
				case (ctrl.act)
					qdcm_pkg::ACT_CLEAR: begin
						used_q <= '0;
						idx_q <= '0;
					end
					qdcm_pkg::ACT_SWEEP_INIT: begin
						changed_q <= 1'b0;
						idx_q <= '0;
					end
					qdcm_pkg::ACT_EMIT_INIT: begin
						idx_q <= '0;
					end
					qdcm_pkg::ACT_MARK_ROOT, qdcm_pkg::ACT_MARK_LIVE: begin
						used_q <= used_q | mark_vec;
						if ((mark_vec & ~used_q) != '0) begin
							changed_q <= 1'b1;
						end
						if (more) begin
							idx_q <= idx_q + IdxW'(1);
						end
					end
					qdcm_pkg::ACT_EMIT: begin
						if (more) begin
							idx_q <= idx_q + IdxW'(1);
						end
					end
					qdcm_pkg::ACT_DONE: begin
						count_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (run && ctrl.act == qdcm_pkg::ACT_EMIT) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (run && ctrl.act == qdcm_pkg::ACT_EMIT) begin
			out_idx_q <= 6'(idx_q);
			out_live_q <= live;
			out_last_q <= !more;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {1'b0, out_live_q, out_idx_q};
	assign m_tlast = out_last_q;

endmodule

>>> hw/rtl/qdcm_checker.sv
module qdcm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// A stalled output word holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// The last word of a block starts the analysis, so input stops at once.
	a_last_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken right after the last word of a block");

	// While a block still has results to give, no new word is taken.
	a_no_input_mid_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken while results of a block are pending");

	// Reset keeps the output empty.
	a_idle_in_reset: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output word offered during reset");

endmodule

bind quad_dead_code_marker qdcm_checker u_qdcm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

>>> dv/quad_dead_code_marker_test.sv
`timescale 1ns / 100ps

module quad_dead_code_marker_test;

	localparam logic [1:0] ClsPlain = 2'd0;
	localparam logic [1:0] ClsSpare = 2'd3;
	localparam int QuietLimit = 40000;
	localparam int HoldCycles = 600;
	localparam int TailCycles = 200;

	typedef struct packed {
		logic [qdcm_pkg::VarIdW-1:0] index;
		logic                        live;
		logic                        final_res;
	} verdict_t;

	class liveness_tracker;
		qdcm_pkg::quad_t block_quads[$];
		verdict_t        verdicts_due[$];
		bit              var_used[qdcm_pkg::VarSpace];
		bit              grew;
		int              mismatches;

		function bit names_var(logic valid, logic [qdcm_pkg::VarIdW-1:0] id);
			return valid && int'(id) < qdcm_pkg::MaxVarsDef;
		endfunction

		function void mark_var(logic valid, logic [qdcm_pkg::VarIdW-1:0] id);
			if (names_var(valid, id) && !var_used[id]) begin
				var_used[id] = 1'b1;
				grew = 1'b1;
			end
		endfunction

		function void take_quad(qdcm_pkg::quad_t q, logic is_last);
			verdict_t v;
			if (block_quads.size() < qdcm_pkg::MaxQuadsDef) block_quads.push_back(q);
			if (!is_last) return;
			foreach (var_used[k]) var_used[k] = 1'b0;
			foreach (block_quads[i]) begin
				if (block_quads[i].cls == qdcm_pkg::ClsRoot) begin
					mark_var(block_quads[i].a1v, block_quads[i].a1);
					mark_var(block_quads[i].a2v, block_quads[i].a2);
				end
			end
			do begin
				grew = 1'b0;
				foreach (block_quads[i]) begin
					if (names_var(block_quads[i].dv, block_quads[i].d) &&
							var_used[block_quads[i].d]) begin
						mark_var(block_quads[i].a1v, block_quads[i].a1);
						mark_var(block_quads[i].a2v, block_quads[i].a2);
					end
				end
			end while (grew);
			foreach (block_quads[i]) begin
				v.index = 6'(i);
				v.live = !(names_var(block_quads[i].dv, block_quads[i].d) &&
					!var_used[block_quads[i].d]) || block_quads[i].cls == qdcm_pkg::ClsRoot ||
					block_quads[i].cls == qdcm_pkg::ClsKept;
				v.final_res = (i == block_quads.size() - 1);
				verdicts_due.push_back(v);
			end
			block_quads.delete();
		endfunction

		function void match_verdict(logic [qdcm_pkg::VarIdW-1:0] index, logic live,
				logic final_res);
			verdict_t v;
			if (verdicts_due.size() == 0) begin
				$error("unexpected result word: quad_index %0d live %0b", index, live);
				mismatches++;
				return;
			end
			v = verdicts_due.pop_front();
			if (index !== v.index) begin
				$error("quad_index: expected %0d, actual %0d", v.index, index);
				mismatches++;
			end
			if (live !== v.live) begin
				$error("live: expected %0b, actual %0b", v.live, live);
				mismatches++;
			end
			if (final_res !== v.final_res) begin
				$error("final_res: expected %0b, actual %0b", v.final_res, final_res);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	liveness_tracker             tracker = new();
	int                          send_idle_pct = 0;
	int                          recv_idle_pct = 0;
	int                          quads_sent = 0;
	bit                          hold_off_req = 1'b0;
	logic [qdcm_pkg::VarIdW-1:0] var_pool[8];

	quad_dead_code_marker i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) tracker.take_quad({s_tdata[20:0], s_tuser}, s_tlast);
			if (m_tvalid && m_tready) tracker.match_verdict(m_tdata[5:0], m_tdata[6], m_tlast);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("** quad_dead_code_marker: FAILED **");
		$finish;
	end

	function automatic qdcm_pkg::quad_t qd(logic [1:0] cls, logic a1v, logic [5:0] a1,
			logic a2v, logic [5:0] a2, logic dv, logic [5:0] d);
		qdcm_pkg::quad_t q;
		q.cls = cls;
		q.a1v = a1v;
		q.a1 = a1;
		q.a2v = a2v;
		q.a2 = a2;
		q.dv = dv;
		q.d = d;
		return q;
	endfunction

	function automatic qdcm_pkg::quad_t pick_quad();
		qdcm_pkg::quad_t q;
		int r;
		r = $urandom_range(99);
		q.cls = (r < 60) ? ClsPlain : (r < 80) ? qdcm_pkg::ClsRoot :
			(r < 92) ? qdcm_pkg::ClsKept : ClsSpare;
		q.a1 = var_pool[$urandom_range(7)];
		q.a1v = ($urandom_range(9) != 0);
		q.a2 = var_pool[$urandom_range(7)];
		q.a2v = ($urandom_range(3) != 0);
		q.d = var_pool[$urandom_range(7)];
		q.dv = ($urandom_range(9) != 0);
		if ($urandom_range(15) == 0) q = 23'($urandom);
		return q;
	endfunction

	task automatic offer_quad(input qdcm_pkg::quad_t q, input logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, q[22:2]};
		s_tuser <= q.cls;
		s_tlast <= is_last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		quads_sent++;
	endtask

	task automatic send_block(input qdcm_pkg::quad_t blk[$]);
		foreach (blk[i]) offer_quad(blk[i], i == blk.size() - 1);
	endtask

	task automatic send_random_blocks(input int target);
		qdcm_pkg::quad_t blk[$];
		int n;
		while (quads_sent < target) begin
			foreach (var_pool[k]) var_pool[k] = 6'($urandom_range(63));
			n = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
			blk.delete();
			repeat (n) blk.push_back(pick_quad());
			send_block(blk);
		end
	endtask

	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.verdicts_due.size() != 0) @(posedge clk);
	endtask

	initial begin
		qdcm_pkg::quad_t blk[$];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 29;
		recv_idle_pct = 72;

		blk = '{qd(qdcm_pkg::ClsRoot, 1, 0, 1, 63, 0, 0)};
		send_block(blk);

		// The chain 5 <- 63 <- {0,1} is resolved against load order over several sweeps.
		blk = '{qd(ClsPlain, 1, 0, 1, 1, 1, 63),
			qd(ClsPlain, 1, 63, 0, 0, 1, 5),
			qd(qdcm_pkg::ClsRoot, 1, 5, 0, 0, 0, 0),
			qd(ClsPlain, 1, 1, 1, 2, 1, 10),
			qd(qdcm_pkg::ClsKept, 0, 0, 0, 0, 1, 20),
			qd(ClsSpare, 1, 5, 1, 63, 1, 30),
			qd(ClsPlain, 1, 0, 1, 0, 0, 63),
			qd(ClsPlain, 0, 0, 0, 0, 1, 0),
			qd(qdcm_pkg::ClsRoot, 0, 63, 0, 63, 1, 63)};
		send_block(blk);

		blk = '{qd(ClsSpare, 1, 63, 1, 63, 1, 63)};
		send_block(blk);
		blk = '{qd(ClsPlain, 0, 0, 0, 0, 0, 0)};
		send_block(blk);

		blk = '{qd(ClsPlain, 1, 7, 0, 0, 1, 7),
			qd(ClsPlain, 1, 8, 1, 7, 1, 8),
			qd(qdcm_pkg::ClsRoot, 1, 8, 0, 0, 0, 0)};
		send_block(blk);

		send_random_blocks(75);
		pause_until_drained();

		send_idle_pct = 72;
		recv_idle_pct = 29;

		// A full block whose marking walks back one link per sweep; the two extra
		// words arrive with the store full and are dropped.
		blk.delete();
		blk.push_back(qd(ClsPlain, 0, 0, 0, 0, 1, 0));
		for (int i = 1; i < 63; i++) begin
			blk.push_back(qd(ClsPlain, 1, 6'(i - 1), 0, 6'($urandom_range(63)), 1, 6'(i)));
		end
		blk.push_back(qd(qdcm_pkg::ClsRoot, 1, 62, 0, 0, 0, 0));
		blk.push_back(qd(qdcm_pkg::ClsRoot, 1, 63, 1, 63, 0, 0));
		blk.push_back(qd(ClsPlain, 0, 0, 0, 0, 1, 63));
		send_block(blk);

		send_random_blocks(165);
		pause_until_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_req = 1'b1;
		send_random_blocks(255);
		pause_until_drained();

		repeat (TailCycles) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.verdicts_due.size() == 0) begin
			$display("** quad_dead_code_marker: PASSED **");
		end else begin
			$display("** quad_dead_code_marker: FAILED **");
		end
		$finish;
	end

endmodule
